// File: sv/tbo_pkg.sv
// Shared constants, codes and types of the triangle and box overlap test.
package tbo_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int TOL_BITS = 16;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1074;
	localparam int BARY_SHIFT = 30;

	typedef enum logic [1:0] {
		DEC_NONE   = 2'd0,
		DEC_VERTEX = 2'd1,
		DEC_CORNER = 2'd2,
		DEC_EDGE   = 2'd3
	} decided_t;

	// Index 0 is the side of edge bc, 1 of edge ca, 2 of edge ab.
	typedef struct packed {
		logic       in_tri;
		logic [2:0] pos;
		logic [2:0] neg;
	} corner_res_t;
endpackage

// File: sv/triangle_box_overlap_test_core.sv
// Throughput: one pair per clock while the output is not stalled; six register
// stages carry the cross products, the slack products and the final decision,
// all advancing together.
// A stalled output holds every stage; the input is ready whenever the output
// register is empty or being taken.
// Reset clears the valid bits and loads the inside tolerance with 1074.
module triangle_box_overlap_test_core #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] vert_a_x,
	input  logic signed [COORD_BITS-1:0] vert_a_y,
	input  logic signed [COORD_BITS-1:0] vert_b_x,
	input  logic signed [COORD_BITS-1:0] vert_b_y,
	input  logic signed [COORD_BITS-1:0] vert_c_x,
	input  logic signed [COORD_BITS-1:0] vert_c_y,
	input  logic signed [COORD_BITS-1:0] box_center_x,
	input  logic signed [COORD_BITS-1:0] box_center_y,
	input  logic [COORD_BITS-2:0]        box_half_w,
	input  logic [COORD_BITS-2:0]        box_half_h,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         overlaps,
	output tbo_pkg::decided_t            decided_by,
	output logic                         degenerate,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tbo_pkg::TOL_BITS-1:0] cfg_data
);
	import tbo_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int EW  = CW + 1;
	localparam int WW  = CW + 2;
	localparam int PW  = 2*CW + 2;
	localparam int DW  = 2*CW + 3;
	localparam int TDW = 2*CW + 20;

	logic en;
	logic [TOL_BITS-1:0] tol_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;

	// stage 1
	logic signed [CW-1:0] vx_s1 [3];
	logic signed [CW-1:0] vy_s1 [3];
	logic signed [EW-1:0] left_s1, right_s1, bot_s1, top_s1;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1;

	// stage 2
	logic signed [PW-1:0] dp0_s2, dp1_s2;
	logic signed [WW-1:0] wx_s2 [4];
	logic signed [WW-1:0] wy_s2 [4];
	logic signed [EW-1:0] e1x_s2, e1y_s2, e2x_s2, e2y_s2;
	logic bbox_s2, vin_s2, bbox_s3, vin_s3, bbox_s4, vin_s4, bbox_s5, vin_s5;
	logic [2:0] seg_s2, seg_s3, seg_s4, seg_s5;

	logic signed [DW-1:0] d_s3, d_s4;
	logic signed [TDW-1:0] tol_d_s4;
	logic deg_s4, flip_s4, deg_s5;

	corner_res_t res_s5 [4];

	logic bbox_c, vin_c;
	logic [2:0] seg_c, edge_hit_c;
	logic [3:0] ins_c;
	logic signed [EW-1:0] cpx [4];
	logic signed [EW-1:0] cpy [4];
	decided_t dec_c;
	logic overlaps_q, degenerate_q;
	decided_t decided_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign overlaps  = overlaps_q;
	assign decided_by = decided_q;
	assign degenerate = degenerate_q;

	function automatic logic signed [EW-1:0] min3(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b, input logic signed [EW-1:0] c);
		logic signed [EW-1:0] m;
		m = (a < b) ? a : b;
		return (c < m) ? c : m;
	endfunction

	function automatic logic signed [EW-1:0] max3(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b, input logic signed [EW-1:0] c);
		logic signed [EW-1:0] m;
		m = (a > b) ? a : b;
		return (c > m) ? c : m;
	endfunction

	// Stage 2 flags: bounding boxes, vertex in box, edge extent against the box.
	always_comb begin
		bbox_c = (min3(EW'(vx_s1[0]), EW'(vx_s1[1]), EW'(vx_s1[2])) <= right_s1) &&
			(max3(EW'(vx_s1[0]), EW'(vx_s1[1]), EW'(vx_s1[2])) >= left_s1) &&
			(min3(EW'(vy_s1[0]), EW'(vy_s1[1]), EW'(vy_s1[2])) <= top_s1) &&
			(max3(EW'(vy_s1[0]), EW'(vy_s1[1]), EW'(vy_s1[2])) >= bot_s1);
		vin_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (EW'(vx_s1[i]) >= left_s1 && EW'(vx_s1[i]) <= right_s1 &&
				EW'(vy_s1[i]) >= bot_s1 && EW'(vy_s1[i]) <= top_s1) begin
				vin_c = 1'b1;
			end
		end
		// Bit k is the edge opposite vertex k: bc, ca, ab.
		for (int k = 0; k < 3; k++) begin
			seg_c[k] =
				(min3(EW'(vx_s1[(k+1)%3]), EW'(vx_s1[(k+2)%3]), EW'(vx_s1[(k+2)%3])) <= right_s1) &&
				(max3(EW'(vx_s1[(k+1)%3]), EW'(vx_s1[(k+2)%3]), EW'(vx_s1[(k+2)%3])) >= left_s1) &&
				(min3(EW'(vy_s1[(k+1)%3]), EW'(vy_s1[(k+2)%3]), EW'(vy_s1[(k+2)%3])) <= top_s1) &&
				(max3(EW'(vy_s1[(k+1)%3]), EW'(vy_s1[(k+2)%3]), EW'(vy_s1[(k+2)%3])) >= bot_s1);
		end
		cpx[0] = left_s1;  cpy[0] = bot_s1;
		cpx[1] = left_s1;  cpy[1] = top_s1;
		cpx[2] = right_s1; cpy[2] = top_s1;
		cpx[3] = right_s1; cpy[3] = bot_s1;
	end

	// An edge meets the box when its extent overlaps and the corners do not all
	// lie strictly on one side of its line.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			edge_hit_c[k] = seg_s5[k] &&
				!((res_s5[0].pos[k] && res_s5[1].pos[k] && res_s5[2].pos[k] && res_s5[3].pos[k]) ||
				  (res_s5[0].neg[k] && res_s5[1].neg[k] && res_s5[2].neg[k] && res_s5[3].neg[k]));
		end
		for (int j = 0; j < 4; j++) begin
			ins_c[j] = res_s5[j].in_tri;
		end
		if (!bbox_s5) begin
			dec_c = DEC_NONE;
		end else if (vin_s5) begin
			dec_c = DEC_VERTEX;
		end else if (!deg_s5 && |ins_c) begin
			dec_c = DEC_CORNER;
		end else if (|edge_hit_c) begin
			dec_c = DEC_EDGE;
		end else begin
			dec_c = DEC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (en) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				out_valid_q <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1[0] <= vert_a_x; vy_s1[0] <= vert_a_y;
			vx_s1[1] <= vert_b_x; vy_s1[1] <= vert_b_y;
			vx_s1[2] <= vert_c_x; vy_s1[2] <= vert_c_y;
			left_s1  <= EW'(box_center_x) - EW'($signed({1'b0, box_half_w}));
			right_s1 <= EW'(box_center_x) + EW'($signed({1'b0, box_half_w}));
			bot_s1   <= EW'(box_center_y) - EW'($signed({1'b0, box_half_h}));
			top_s1   <= EW'(box_center_y) + EW'($signed({1'b0, box_half_h}));
			e1x_s1 <= EW'(vert_b_x) - EW'(vert_a_x);
			e1y_s1 <= EW'(vert_b_y) - EW'(vert_a_y);
			e2x_s1 <= EW'(vert_c_x) - EW'(vert_a_x);
			e2y_s1 <= EW'(vert_c_y) - EW'(vert_a_y);

			dp0_s2 <= PW'(e1x_s1) * PW'(e2y_s1);
			dp1_s2 <= PW'(e1y_s1) * PW'(e2x_s1);
			for (int j = 0; j < 4; j++) begin
				wx_s2[j] <= WW'(cpx[j]) - WW'(vx_s1[0]);
				wy_s2[j] <= WW'(cpy[j]) - WW'(vy_s1[0]);
			end
			e1x_s2 <= e1x_s1; e1y_s2 <= e1y_s1;
			e2x_s2 <= e2x_s1; e2y_s2 <= e2y_s1;
			bbox_s2 <= bbox_c; vin_s2 <= vin_c; seg_s2 <= seg_c;

			d_s3 <= DW'(dp0_s2) - DW'(dp1_s2);
			bbox_s3 <= bbox_s2; vin_s3 <= vin_s2; seg_s3 <= seg_s2;

			d_s4 <= d_s3;
			tol_d_s4 <= TDW'($signed({1'b0, tol_q})) * TDW'(d_s3);
			deg_s4 <= (d_s3 == '0);
			flip_s4 <= d_s3[DW-1];
			bbox_s4 <= bbox_s3; vin_s4 <= vin_s3; seg_s4 <= seg_s3;

			deg_s5 <= deg_s4;
			bbox_s5 <= bbox_s4; vin_s5 <= vin_s4; seg_s5 <= seg_s4;

			overlaps_q <= (dec_c != DEC_NONE);
			decided_q <= dec_c;
			degenerate_q <= deg_s5;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_corner
		tbo_corner #(.COORD_BITS(COORD_BITS)) u_corner (
			.clk      (clk),
			.en       (en),
			.wx_s2    (wx_s2[g]),
			.wy_s2    (wy_s2[g]),
			.e1x_s2   (e1x_s2),
			.e1y_s2   (e1y_s2),
			.e2x_s2   (e2x_s2),
			.e2y_s2   (e2y_s2),
			.d_s3     (d_s3),
			.d_s4     (d_s4),
			.tol_d_s4 (tol_d_s4),
			.flip_s4  (flip_s4),
			.res_s5   (res_s5[g])
		);
	end

	a_none_iff_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (overlaps == (decided_by != DEC_NONE)))
		else $error("overlap flag disagrees with deciding test");
	a_corner_not_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decided_by == DEC_CORNER |-> !degenerate)
		else $error("corner decision on a degenerate triangle");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_s5) && $stable(v_s1))
		else $error("pipeline moved during a stall");
endmodule

// File: sv/tbo_corner.sv
// One box corner: barycentric numerators, slack test and edge side signs.
module tbo_corner #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS+1:0] wx_s2,
	input  logic signed [COORD_BITS+1:0] wy_s2,
	input  logic signed [COORD_BITS:0]   e1x_s2,
	input  logic signed [COORD_BITS:0]   e1y_s2,
	input  logic signed [COORD_BITS:0]   e2x_s2,
	input  logic signed [COORD_BITS:0]   e2y_s2,
	input  logic signed [2*COORD_BITS+2:0]  d_s3,
	input  logic signed [2*COORD_BITS+2:0]  d_s4,
	input  logic signed [2*COORD_BITS+19:0] tol_d_s4,
	input  logic                         flip_s4,
	output tbo_pkg::corner_res_t         res_s5
);
	import tbo_pkg::*;

	localparam int MW = 2*COORD_BITS + 3;
	localparam int NW = 2*COORD_BITS + 6;
	localparam int SW = 2*COORD_BITS + 38;

	logic signed [MW-1:0] m0_s3, m1_s3, m2_s3, m3_s3;
	logic signed [NW-1:0] n1_c, n2_c;
	logic signed [NW-1:0] n_s4 [3];
	logic signed [SW-1:0] s_c [3];
	logic signed [SW-1:0] t_c [3];
	logic [2:0] ok_c;
	corner_res_t res_c;

	assign n1_c = NW'(m0_s3) - NW'(m1_s3);
	assign n2_c = NW'(m2_s3) - NW'(m3_s3);

	// Compare n/d against the slack window as cross-multiplied sums.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_c[k] = (SW'(n_s4[k]) <<< BARY_SHIFT) + SW'(tol_d_s4);
			t_c[k] = (SW'(d_s4) <<< BARY_SHIFT) + SW'(tol_d_s4)
				- (SW'(n_s4[k]) <<< BARY_SHIFT);
			if (flip_s4) begin
				ok_c[k] = (s_c[k][SW-1] || s_c[k] == '0) && (t_c[k][SW-1] || t_c[k] == '0);
			end else begin
				ok_c[k] = !s_c[k][SW-1] && !t_c[k][SW-1];
			end
			res_c.pos[k] = !n_s4[k][NW-1] && n_s4[k] != '0;
			res_c.neg[k] = n_s4[k][NW-1];
		end
		res_c.in_tri = &ok_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s3 <= MW'(wx_s2) * MW'(e2y_s2);
			m1_s3 <= MW'(wy_s2) * MW'(e2x_s2);
			m2_s3 <= MW'(e1x_s2) * MW'(wy_s2);
			m3_s3 <= MW'(e1y_s2) * MW'(wx_s2);
			n_s4[0] <= NW'(d_s3) - n1_c - n2_c;
			n_s4[1] <= n1_c;
			n_s4[2] <= n2_c;
			res_s5 <= res_c;
		end
	end
endmodule
